/* rtl/core/dphv_pkg.sv */
// Shared types, constants and hash helpers for the dual payload hash verifier.
`default_nettype none

package dphv_pkg;

    localparam int unsigned HASH_W      = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned OUT_COUNT_W = 32;
    localparam int unsigned CFG_INDEX_W = 8;

    // FNV-1a 64 offset basis and golden-ratio seed of the combine hash
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [HASH_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;

    // Secondary hash shift amounts
    localparam int unsigned SEC_SHL = 6;
    localparam int unsigned SEC_SHR = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_PRIMARY   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_SECONDARY = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              last;
    } in_word_t;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] payload_len;
        logic [HASH_W-1:0]      primary_hash;
        logic [HASH_W-1:0]      secondary_hash;
        logic                   primary_match;
        logic                   secondary_match;
        logic                   intact;
    } result_word_t;

    typedef struct packed {
        logic [HASH_W-1:0] primary;
        logic [HASH_W-1:0] secondary;
    } expected_t;

    // Multiply by the FNV-64 prime 0x100000001b3 as a sum of shifted copies
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                + (x << 4) + (x << 1) + x;
    endfunction

    // One step of the shift-add-xor combine hash
    function automatic logic [HASH_W-1:0] sec_step(input logic [HASH_W-1:0] s,
                                                   input logic [BYTE_W-1:0] b);
        sec_step = s ^ ({{(HASH_W-BYTE_W){1'b0}}, b} + GOLDEN
                        + (s << SEC_SHL) + (s >> SEC_SHR));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dphv_in_stage.sv */
// Input register of the hash verifier: holds one accepted word until it is consumed.
`default_nettype none

module dphv_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dphv_pkg::in_word_t s_data,
    input  wire logic               consume,
    output logic                    word_valid,
    output dphv_pkg::in_word_t      word
);

    logic               valid_reg;
    logic               valid_next;
    dphv_pkg::in_word_t word_reg;

    // Take a new word when empty or when the held word leaves this cycle
    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_data;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

/* rtl/core/dphv_hash_core.sv */
// Running FNV-1a and combine hashes, saturating byte count and match logic.
`default_nettype none

module dphv_hash_core #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step,
    input  wire dphv_pkg::in_word_t     word,
    input  wire dphv_pkg::expected_t    expected,
    output dphv_pkg::result_word_t      result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [dphv_pkg::HASH_W-1:0] primary_reg;
    logic [dphv_pkg::HASH_W-1:0] primary_next;
    logic [dphv_pkg::HASH_W-1:0] secondary_reg;
    logic [dphv_pkg::HASH_W-1:0] secondary_next;
    logic [COUNT_BITS-1:0]       count_reg;
    logic [COUNT_BITS-1:0]       count_next;

    logic [dphv_pkg::HASH_W-1:0] primary_abs;
    logic [dphv_pkg::HASH_W-1:0] secondary_abs;
    logic [COUNT_BITS-1:0]       count_abs;
    logic                        pm;
    logic                        sm;

    always_comb begin
        primary_abs   = primary_reg;
        secondary_abs = secondary_reg;
        count_abs     = count_reg;
        if (word.byte_present) begin
            primary_abs   = dphv_pkg::fnv_mul(primary_reg
                            ^ {{(dphv_pkg::HASH_W-dphv_pkg::BYTE_W){1'b0}}, word.data_byte});
            secondary_abs = dphv_pkg::sec_step(secondary_reg, word.data_byte);
            // hold the count at its maximum once reached
            if (count_reg != COUNT_MAX) begin
                count_abs = count_reg + COUNT_BITS'(1);
            end
        end

        pm = (primary_abs == expected.primary);
        sm = (secondary_abs == expected.secondary);

        result.payload_len     = dphv_pkg::OUT_COUNT_W'(count_abs);
        result.primary_hash    = primary_abs;
        result.secondary_hash  = secondary_abs;
        result.primary_match   = pm;
        result.secondary_match = sm;
        result.intact          = pm && sm;

        primary_next   = primary_reg;
        secondary_next = secondary_reg;
        count_next     = count_reg;
        if (step) begin
            if (word.last) begin
                // restart for the next payload
                primary_next   = dphv_pkg::FNV_BASIS;
                secondary_next = dphv_pkg::GOLDEN;
                count_next     = '0;
            end else begin
                primary_next   = primary_abs;
                secondary_next = secondary_abs;
                count_next     = count_abs;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primary_reg   <= dphv_pkg::FNV_BASIS;
            secondary_reg <= dphv_pkg::GOLDEN;
            count_reg     <= '0;
        end else begin
            primary_reg   <= primary_next;
            secondary_reg <= secondary_next;
            count_reg     <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dphv_out_stage.sv */
// Result register of the hash verifier: holds one result word until the sink takes it.
`default_nettype none

module dphv_out_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire dphv_pkg::result_word_t load_data,
    output logic                        free,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output dphv_pkg::result_word_t      m_data
);

    logic                   valid_reg;
    logic                   valid_next;
    dphv_pkg::result_word_t data_reg;

    // Slot can take a word when empty or drained this cycle
    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/core/dual_payload_hash_verify.sv */
// Top level of the dual payload hash verifier: channels, config registers and stage control.
`default_nettype none
// Usage:
//   Stream a payload into the s_ channel, one word per byte (byte_present high),
//   and mark its final word with last. A word with byte_present low and last high
//   closes the payload (an empty payload if nothing came before); a word with both
//   low changes nothing. Each closing word produces one result word on the m_
//   channel: saturating byte count, FNV-1a 64 hash, combine hash, and match flags
//   against the expected hashes written on the cfg_ channel (index 0 primary,
//   index 1 secondary; other indexes are dropped). cfg_ready is always high.
// Timing:
//   One word per cycle sustained while no closing word waits for a free output
//   register. A closing word passes from the input register to the output
//   register, which drives m_. The rate rests on the combinational update of the
//   running hashes: a shift-add multiply by the FNV prime and a four-way add.
// Reset (aresetn low, synchronous): both channels empty, running hashes back to
//   their seeds, count to zero, expected hashes to zero.
// Stall: a result waits in the output register while m_ready is low; data words
//   keep flowing, and a closing word waits in the input register until the
//   output register frees.

module dual_payload_hash_verify #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dphv_pkg::in_word_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dphv_pkg::result_word_t                   m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dphv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dphv_pkg::HASH_W-1:0]         cfg_data
);

    dphv_pkg::expected_t    expected_reg;
    dphv_pkg::expected_t    expected_next;
    dphv_pkg::in_word_t     word;
    dphv_pkg::result_word_t result;
    logic                   word_valid;
    logic                   out_free;
    logic                   consume;
    logic                   load;

    // Configuration writes are registered; never stall the config channel
    assign cfg_ready = 1'b1;

    always_comb begin
        expected_next = expected_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dphv_pkg::REG_EXPECTED_PRIMARY: begin
                    expected_next.primary = cfg_data;
                end
                dphv_pkg::REG_EXPECTED_SECONDARY: begin
                    expected_next.secondary = cfg_data;
                end
                default: begin
                    expected_next = expected_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= '0;
        end else begin
            expected_reg <= expected_next;
        end
    end

    // Advance a data word freely; advance a closing word only into a free result slot
    assign consume = word_valid && (!word.last || out_free);
    assign load    = consume && word.last;

    dphv_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .consume    (consume),
        .word_valid (word_valid),
        .word       (word)
    );

    dphv_hash_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hash_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (consume),
        .word     (word),
        .expected (expected_reg),
        .result   (result)
    );

    dphv_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .load_data (result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
